FILE: design/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the polyline segment tessellator.
// ----------------------------------------------------------------------------
package pst_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_DIV,
    ST_CAP,
    ST_STEP,
    ST_EMIT,
    ST_LAST
  } pst_state_t;

  typedef struct packed {
    logic load;        // capture vertex, form deltas
    logic square;      // register squares
    logic sum;         // register 66-bit sum, start sqrt
    logic sqrt_step;   // one root digit
    logic div_start;   // start sub divide
    logic div_step;    // one quotient bit
    logic cap;         // limit sub, start step divide
    logic step_div;    // one step quotient bit
    logic advance;     // add step to current point
  } pst_cmd_t;

  typedef struct packed {
    logic pass;        // vertex goes through alone
    logic dist_zero;
    logic sub_zero;
    logic count_done;  // iteration counter expired
    logic emit_done;   // last inserted point emitted
  } pst_sts_t;

endpackage

FILE: design/pst_datapath.sv
// ----------------------------------------------------------------------------
// pst_datapath
// Deltas, squares, bit-serial square root, sub divide, step divide, points.
// ----------------------------------------------------------------------------
module pst_datapath import pst_pkg::*; #(
  parameter int MaxSub = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        threshold,
  input  logic [31:0]        vx,
  input  logic [31:0]        vy,
  input  logic               first,
  input  pst_cmd_t           cmd,
  output pst_sts_t           sts,
  output logic [31:0]        pt_x,
  output logic [31:0]        pt_y,
  output logic [31:0]        vtx_x,
  output logic [31:0]        vtx_y,
  output logic               capped
);

  localparam int SubW = $clog2(MaxSub + 1);

  logic signed [32:0] dx_r, dy_r;
  logic [32:0]        adx, ady;
  logic [65:0]        sqx_r, sqy_r;
  logic [65:0]        rad_r;
  logic [32:0]        root_r;
  logic [34:0]        rem_r;
  logic [5:0]         cnt_r;
  logic [32:0]        dq_r;      // dividend shifted / quotient
  logic [32:0]        drem_r;
  logic [32:0]        subq;
  logic [SubW-1:0]    sub_r, emit_r;
  logic [33:0]        sx_q_r, sy_q_r;   // magnitude quotient
  logic [6:0]         srem_x_r, srem_y_r;
  logic [31:0]        vx_r, vy_r, px_r, py_r;
  logic [31:0]        cx_r, cy_r;
  logic               have_r, cap_r, pass_r;
  logic               sgnx_r, sgny_r;
  logic [6:0]         dvs;
  logic [34:0]        trial, rem_sh;
  logic [33:0]        drem_sh;
  logic [7:0]         sxr, syr;
  logic signed [32:0] stx, sty;

  assign adx = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ady = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign rem_sh = {rem_r[32:0], rad_r[65:64]};
  assign trial  = {root_r[32:0], 2'b01};
  assign drem_sh = {drem_r, dq_r[32]};
  assign dvs = 7'(sub_r) + 7'd1;
  assign sxr = {srem_x_r, sx_q_r[33]};
  assign syr = {srem_y_r, sy_q_r[33]};
  assign stx = sgnx_r ? -$signed({1'b0, sx_q_r[31:0]}) : $signed({1'b0, sx_q_r[31:0]});
  assign sty = sgny_r ? -$signed({1'b0, sy_q_r[31:0]}) : $signed({1'b0, sy_q_r[31:0]});
  assign subq = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r   <= '0;
      py_r   <= '0;
      have_r <= 1'b0;
    end else if (cmd.load) begin
      px_r   <= vx;
      py_r   <= vy;
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r  <= vx;
      vy_r  <= vy;
      cx_r  <= px_r;
      cy_r  <= py_r;
      dx_r  <= $signed({vx[31], vx}) - $signed({px_r[31], px_r});
      dy_r  <= $signed({vy[31], vy}) - $signed({py_r[31], py_r});
      sgnx_r <= 1'b0;
      sgny_r <= 1'b0;
      cap_r <= 1'b0;
      pass_r <= first | ~have_r | (threshold == '0);
    end
    if (cmd.square) begin
      sqx_r <= 66'(64'(adx[31:0]) * 64'(adx[31:0]));
      sqy_r <= 66'(64'(ady[31:0]) * 64'(ady[31:0]));
      sgnx_r <= dx_r[32];
      sgny_r <= dy_r[32];
    end
    if (cmd.sum) begin
      rad_r  <= sqx_r + sqy_r;
      root_r <= '0;
      rem_r  <= '0;
      cnt_r  <= 6'd32;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[63:0], 2'b00};
      cnt_r <= cnt_r - 6'd1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[31:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[31:0], 1'b0};
      end
    end
    if (cmd.div_start) begin
      dq_r   <= root_r - 33'd1;
      drem_r <= '0;
      cnt_r  <= 6'd33;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r - 6'd1;
      if (drem_sh >= {2'b0, threshold}) begin
        drem_r <= 33'(drem_sh - {2'b0, threshold});
        dq_r   <= {dq_r[31:0], 1'b1};
      end else begin
        drem_r <= drem_sh[32:0];
        dq_r   <= {dq_r[31:0], 1'b0};
      end
    end
    if (cmd.cap) begin
      if (subq > 33'(MaxSub)) begin
        sub_r <= SubW'(MaxSub);
        cap_r <= 1'b1;
      end else begin
        sub_r <= SubW'(subq);
      end
      emit_r <= '0;
      sx_q_r <= {adx, 1'b0};
      sy_q_r <= {ady, 1'b0};
      srem_x_r <= '0;
      srem_y_r <= '0;
      cnt_r <= 6'd33;
    end
    if (cmd.step_div) begin
      cnt_r <= cnt_r - 6'd1;
      if (sxr >= {1'b0, dvs}) begin
        srem_x_r <= 7'(sxr - {1'b0, dvs});
        sx_q_r   <= {sx_q_r[32:0], 1'b1};
      end else begin
        srem_x_r <= sxr[6:0];
        sx_q_r   <= {sx_q_r[32:0], 1'b0};
      end
      if (syr >= {1'b0, dvs}) begin
        srem_y_r <= 7'(syr - {1'b0, dvs});
        sy_q_r   <= {sy_q_r[32:0], 1'b1};
      end else begin
        srem_y_r <= syr[6:0];
        sy_q_r   <= {sy_q_r[32:0], 1'b0};
      end
    end
    if (cmd.advance) begin
      cx_r <= 32'($signed(cx_r) + stx);
      cy_r <= 32'($signed(cy_r) + sty);
      emit_r <= emit_r + SubW'(1);
    end
  end

  assign sts.pass       = pass_r;
  assign sts.dist_zero  = (root_r == '0);
  assign sts.sub_zero   = (sub_r == '0);
  assign sts.count_done = (cnt_r == '0);
  assign sts.emit_done  = (emit_r == sub_r);
  assign pt_x   = 32'($signed(cx_r) + stx);
  assign pt_y   = 32'($signed(cy_r) + sty);
  assign vtx_x  = vx_r;
  assign vtx_y  = vy_r;
  assign capped = cap_r;

endmodule

FILE: design/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer: square, root, divide, step divide, then point emission.
// ----------------------------------------------------------------------------
module pst_ctrl import pst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_inserted,
  output logic     out_last,
  output logic     out_take_pt,
  input  pst_sts_t sts,
  output pst_cmd_t cmd
);

  pst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    out_inserted = 1'b0;
    out_last     = 1'b0;
    out_take_pt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sts.pass) begin
          state_nxt = ST_LAST;
        end else begin
          cmd.square = 1'b1;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.count_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.dist_zero) begin
          state_nxt = ST_LAST;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_CAP;
        end
      end
      ST_CAP: begin
        if (!sts.count_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.cap   = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!sts.count_done) begin
          cmd.step_div = 1'b1;
        end else if (sts.sub_zero) begin
          state_nxt = ST_LAST;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid    = 1'b1;
        out_inserted = 1'b1;
        out_take_pt  = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
        end
        if (sts.emit_done) begin
          out_valid   = 1'b0;
          cmd.advance = 1'b0;
          state_nxt   = ST_LAST;
        end
      end
      ST_LAST: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: design/polyline_segment_tessellator_top.sv
// A pass-through vertex goes straight out and a repeated vertex after the root;
// a subdivided segment runs a 33-step root, a 33-step divide and a 33-step
// step divide before its first point, and its vertex follows its points.
// One vertex at a time; a new vertex is taken once the previous one is sent out.
// Points leave one per cycle while out_ready is high. Active-low synchronous
// reset clears the sequencer, previous vertex and its flag, and threshold.
// ----------------------------------------------------------------------------
// polyline_segment_tessellator_top
// Splits polyline segments into evenly spaced points below a length limit.
// ----------------------------------------------------------------------------
module polyline_segment_tessellator_top import pst_pkg::*; #(
  parameter int MAX_SUBDIVISIONS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_tessellation_threshold,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_vertex_x,
  input  logic [31:0] in_vertex_y,
  input  logic        in_first_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic        out_is_inserted,
  output logic        out_capped,
  output logic        out_last_of_run
);

  logic [31:0] thr_r;
  pst_cmd_t    cmd;
  pst_sts_t    sts;
  logic [31:0] pt_x, pt_y, vtx_x, vtx_y;
  logic        cap, take_pt, last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_tessellation_threshold;
    end
  end

  pst_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_inserted(out_is_inserted), .out_last(last), .out_take_pt(take_pt),
    .sts, .cmd
  );

  pst_datapath #(.MaxSub(MAX_SUBDIVISIONS)) u_dp (
    .clk, .rst_n, .threshold(thr_r), .vx(in_vertex_x), .vy(in_vertex_y),
    .first(in_first_vertex), .cmd, .sts,
    .pt_x, .pt_y, .vtx_x, .vtx_y, .capped(cap)
  );

  assign out_point_x     = take_pt ? pt_x : vtx_x;
  assign out_point_y     = take_pt ? pt_y : vtx_y;
  assign out_capped      = cap;
  assign out_last_of_run = last;

endmodule
